>>> rtl/kse_pkg.sv
// shared types, constants and elaboration-time table builders for the successor expander
// no dependencies
package kse_pkg;

  // successor count limit and index width of the steering table
  localparam int MAX_OUT = 15;
  localparam int KW      = 4;

  // cordic start vector (q30) and number of rotations
  localparam logic signed [31:0] CORDIC_GAIN = 32'sd652032874;
  localparam int CORDIC_STAGES = 15;

  // configuration register indexes
  localparam logic [1:0] REG_GOAL_X = 2'd0;
  localparam logic [1:0] REG_GOAL_Y = 2'd1;
  localparam logic [1:0] REG_HMODE  = 2'd2;

  // heuristic modes
  localparam logic [2:0] H_MANHATTAN  = 3'd0;
  localparam logic [2:0] H_CHEBYSHEV  = 3'd1;
  localparam logic [2:0] H_OCTILE     = 3'd2;
  localparam logic [2:0] H_EUCLID     = 3'd3;
  localparam logic [2:0] H_OCTILE_TIE = 3'd4;

  typedef struct packed {
    logic [15:0]        cost;
    logic signed [23:0] x;
    logic signed [23:0] y;
    logic [15:0]        head;
  } kse_node_t;

  typedef struct packed {
    kse_node_t   node;
    logic [13:0] h;
  } kse_hpay_t;

  // arctangent of 2^-i in units of 2^-16 turn
  function automatic logic [13:0] atan_turn(int i);
    logic [13:0] a;
    case (i)
      0:       a = 14'd8192;
      1:       a = 14'd4836;
      2:       a = 14'd2555;
      3:       a = 14'd1297;
      4:       a = 14'd651;
      5:       a = 14'd326;
      6:       a = 14'd163;
      7:       a = 14'd81;
      8:       a = 14'd41;
      9:       a = 14'd20;
      10:      a = 14'd10;
      11:      a = 14'd5;
      12:      a = 14'd3;
      13:      a = 14'd1;
      14:      a = 14'd1;
      default: a = 14'd0;
    endcase
    return a;
  endfunction

  // shift-subtract divide, elaboration use only
  function automatic longint unsigned udiv(longint unsigned a, longint unsigned b);
    longint unsigned q;
    longint unsigned r;
    q = 0;
    r = 0;
    for (int i = 63; i >= 0; i--) begin
      r = {r[62:0], a[i]};
      if (r >= b) begin
        r = r - b;
        q[i] = 1'b1;
      end
    end
    return q;
  endfunction

  // heading increment for one steering angle in degrees
  function automatic logic [15:0] steer_inc(int deg, int stepq, int wb);
    longint mag;
    longint m;
    longint z;
    longint x;
    longint y;
    longint nx;
    longint c;
    longint s;
    bit flip;
    longint unsigned sq;
    longint unsigned wbu;
    longint unsigned t;
    longint unsigned w;
    longint unsigned p;
    longint unsigned inc;
    sq   = stepq;
    wbu  = wb;
    mag  = (deg < 0) ? -deg : deg;
    m    = udiv(mag * 65536 + 180, 360);
    m    = m & 65535;
    flip = 1'b0;
    if (m >= 49152) begin
      z = m - 65536;
    end else if (m > 16384) begin
      z = m - 32768;
      flip = 1'b1;
    end else begin
      z = m;
    end
    x = 652032874;
    y = 0;
    for (int i = 0; i < CORDIC_STAGES; i++) begin
      if (z >= 0) begin
        nx = x - (y >>> i);
        y  = y + (x >>> i);
        z  = z - longint'(atan_turn(i));
      end else begin
        nx = x + (y >>> i);
        y  = y - (x >>> i);
        z  = z + longint'(atan_turn(i));
      end
      x = nx;
    end
    c = flip ? -x : x;
    s = flip ? -y : y;
    if (s < 0) s = 0;
    if (c <= 0) c = 1;
    t   = udiv(s << 20, c);
    w   = udiv(sq * t, wbu);
    p   = w * 64'd174992710548 + (64'd1 << 43);
    inc = (p >> 44) & 64'hFFFF;
    if (deg < 0) inc = (64'd65536 - inc) & 64'hFFFF;
    return inc[15:0];
  endfunction

  // increments of all steering angles, entry k at bits k*16
  function automatic logic [MAX_OUT*16-1:0] build_tab(int maxt, int step, int stepq, int wb);
    logic [MAX_OUT*16-1:0] tab;
    tab = '0;
    for (int k = 0; k < MAX_OUT; k++) begin
      tab[k*16 +: 16] = steer_inc(-maxt + k * step, stepq, wb);
    end
    return tab;
  endfunction

  // clamp to the 24-bit coordinate range
  function automatic logic signed [23:0] sat24(logic signed [25:0] v);
    logic signed [23:0] r;
    if (v > 26'sd8388607) r = 24'sh7FFFFF;
    else if (v < -26'sd8388608) r = 24'sh800000;
    else r = v[23:0];
    return r;
  endfunction

endpackage

>>> rtl/kse_cordic.sv
// pipelined rotation cordic, one rotation per register stage
// depends on kse_pkg
module kse_cordic (
  input  logic                clk,
  input  logic                rst,
  input  logic                adv,
  input  logic                in_valid,
  input  logic signed [16:0]  in_z,
  input  logic                in_flip,
  input  kse_pkg::kse_node_t  in_node,
  output logic                out_valid,
  output logic signed [31:0]  out_x,
  output logic signed [31:0]  out_y,
  output logic                out_flip,
  output kse_pkg::kse_node_t  out_node
);

  localparam int NS = kse_pkg::CORDIC_STAGES;

  logic                vld  [0:NS];
  logic signed [31:0]  cx   [0:NS];
  logic signed [31:0]  cy   [0:NS];
  logic signed [16:0]  cz   [0:NS];
  logic                flp  [0:NS];
  kse_pkg::kse_node_t  nd   [0:NS];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else if (adv) begin
      vld[0] <= in_valid;
    end
    if (adv) begin
      cx[0]  <= kse_pkg::CORDIC_GAIN;
      cy[0]  <= '0;
      cz[0]  <= in_z;
      flp[0] <= in_flip;
      nd[0]  <= in_node;
    end
  end

  for (genvar i = 0; i < NS; i++) begin : g_rot
    localparam logic signed [16:0] ATAN = $signed({3'b000, kse_pkg::atan_turn(i)});
    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i+1] <= 1'b0;
      end else if (adv) begin
        vld[i+1] <= vld[i];
      end
      if (adv) begin
        if (!cz[i][16]) begin
          cx[i+1] <= cx[i] - (cy[i] >>> i);
          cy[i+1] <= cy[i] + (cx[i] >>> i);
          cz[i+1] <= cz[i] - ATAN;
        end else begin
          cx[i+1] <= cx[i] + (cy[i] >>> i);
          cy[i+1] <= cy[i] - (cx[i] >>> i);
          cz[i+1] <= cz[i] + ATAN;
        end
        flp[i+1] <= flp[i];
        nd[i+1]  <= nd[i];
      end
    end
  end

  assign out_valid = vld[NS];
  assign out_x     = cx[NS];
  assign out_y     = cy[NS];
  assign out_flip  = flp[NS];
  assign out_node  = nd[NS];

endmodule

>>> rtl/kse_isqrt.sv
// pipelined integer square root, one result bit per register stage
// no package dependency
module kse_isqrt #(
  parameter int W  = 49,
  parameter int PW = 8
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     adv,
  input  logic                     in_valid,
  input  logic [W-1:0]             in_value,
  input  logic [PW-1:0]            in_payload,
  output logic                     out_valid,
  output logic [(W+1)/2-1:0]       out_root,
  output logic [PW-1:0]            out_payload
);

  localparam int S = (W + 1) / 2;

  logic           vld [0:S];
  logic [W-1:0]   rem [0:S];
  logic [W-1:0]   rt  [0:S];
  logic [PW-1:0]  pay [0:S];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else if (adv) begin
      vld[0] <= in_valid;
    end
    if (adv) begin
      rem[0] <= in_value;
      rt[0]  <= '0;
      pay[0] <= in_payload;
    end
  end

  for (genvar j = 0; j < S; j++) begin : g_bit
    localparam logic [W:0] B = (W+1)'(1) << (2 * (S - 1 - j));
    logic [W:0] trial;
    assign trial = {1'b0, rt[j]} + B;
    always_ff @(posedge clk) begin
      if (rst) begin
        vld[j+1] <= 1'b0;
      end else if (adv) begin
        vld[j+1] <= vld[j];
      end
      if (adv) begin
        if ({1'b0, rem[j]} >= trial) begin
          rem[j+1] <= rem[j] - trial[W-1:0];
          rt[j+1]  <= (rt[j] >> 1) + B[W-1:0];
        end else begin
          rem[j+1] <= rem[j];
          rt[j+1]  <= rt[j] >> 1;
        end
        pay[j+1] <= pay[j];
      end
    end
  end

  assign out_valid   = vld[S];
  assign out_root    = rt[S][S-1:0];
  assign out_payload = pay[S];

endmodule

>>> rtl/kse_heur.sv
// goal distance heuristic and estimate, pipelined, euclidean through kse_isqrt
// depends on kse_pkg and kse_isqrt
module kse_heur (
  input  logic                clk,
  input  logic                rst,
  input  logic                adv,
  input  logic [8:0]          goal_x,
  input  logic [8:0]          goal_y,
  input  logic [2:0]          hmode,
  input  logic                in_valid,
  input  kse_pkg::kse_node_t  in_node,
  output logic                out_valid,
  output kse_pkg::kse_node_t  out_node,
  output logic [16:0]         out_estimate
);

  localparam int SQW = 49;
  localparam int RW  = (SQW + 1) / 2;

  // distance stage
  logic signed [24:0] ex, ey, ax, ay;
  logic               a_valid;
  logic [23:0]        a_dx, a_dy;
  kse_pkg::kse_node_t a_node;

  always_comb begin
    ex = {in_node.x[23], in_node.x} - $signed({2'b00, goal_x, 14'd0});
    ey = {in_node.y[23], in_node.y} - $signed({2'b00, goal_y, 14'd0});
    ax = ex[24] ? -ex : ex;
    ay = ey[24] ? -ey : ey;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (adv) begin
      a_valid <= in_valid;
    end
    if (adv) begin
      a_dx   <= ax[23:0];
      a_dy   <= ay[23:0];
      a_node <= in_node;
    end
  end

  // squares and the simple modes
  logic [24:0]        dsum;
  logic [23:0]        dlo, dhi;
  logic [26:0]        oct;
  logic [30:0]        oct11;
  logic [13:0]        hsel;
  logic               b_valid;
  logic [47:0]        b_sqx, b_sqy;
  logic [15:0]        b_m4;
  logic [13:0]        b_h;
  kse_pkg::kse_node_t b_node;

  always_comb begin
    dsum  = {1'b0, a_dx} + {1'b0, a_dy};
    dlo   = (a_dx < a_dy) ? a_dx : a_dy;
    dhi   = (a_dx < a_dy) ? a_dy : a_dx;
    oct   = {1'b0, dsum, 1'b0} + {3'b000, dlo};
    oct11 = {4'b0000, oct} * 31'd11;
    unique case (hmode)
      kse_pkg::H_MANHATTAN: hsel = {3'b000, dsum[24:14]};
      kse_pkg::H_CHEBYSHEV: hsel = {4'b0000, dhi[23:14]};
      kse_pkg::H_OCTILE:    hsel = {1'b0, oct[26:14]};
      default:              hsel = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (adv) begin
      b_valid <= a_valid;
    end
    if (adv) begin
      b_sqx  <= a_dx * a_dx;
      b_sqy  <= a_dy * a_dy;
      b_m4   <= oct11[30:15];
      b_h    <= hsel;
      b_node <= a_node;
    end
  end

  // sum of squares and tie-factor mode (divide by five through reciprocal)
  logic [SQW-1:0]     sumsq;
  logic [31:0]        q5;
  kse_pkg::kse_hpay_t c_pay;

  always_comb begin
    sumsq      = {1'b0, b_sqx} + {1'b0, b_sqy};
    q5         = {16'd0, b_m4} * 32'd52429;
    c_pay.node = b_node;
    c_pay.h    = (hmode == kse_pkg::H_OCTILE_TIE) ? q5[31:18] : b_h;
  end

  logic               s_valid;
  logic [RW-1:0]      s_root;
  kse_pkg::kse_hpay_t s_pay;

  kse_isqrt #(
    .W  (SQW),
    .PW ($bits(kse_pkg::kse_hpay_t))
  ) u_isqrt (
    .clk         (clk),
    .rst         (rst),
    .adv         (adv),
    .in_valid    (b_valid),
    .in_value    (sumsq),
    .in_payload  (c_pay),
    .out_valid   (s_valid),
    .out_root    (s_root),
    .out_payload (s_pay)
  );

  logic [13:0] h;
  logic [17:0] est;

  always_comb begin
    h   = (hmode == kse_pkg::H_EUCLID) ? 14'(s_root[RW-1:14]) : s_pay.h;
    est = {2'b00, s_pay.node.cost} + {4'b0000, h};
  end

  assign out_valid    = s_valid;
  assign out_node     = s_pay.node;
  assign out_estimate = est[17] ? 17'h1FFFF : est[16:0];

endmodule

>>> rtl/kinematic_successor_expansion.sv
// path: cordic, step, move, heuristic, expander; then one successor a cycle unless stalled
// flow: a new node is taken only while the expander is idle or as its last successor is taken,
//   the expander issuing min(ceil(2*MAX_TURN_DEG/TURN_STEP_DEG)+1, 15) successors of one node in turn
// reset: rst is synchronous; clears valid bits, expander state and the config registers
// depends on kse_pkg, kse_cordic, kse_heur
module kinematic_successor_expansion #(
  parameter int MAX_TURN_DEG  = 35,
  parameter int TURN_STEP_DEG = 5,
  parameter int STEP_Q14      = 23757,
  parameter int WHEELBASE_Q14 = 8192
) (
  input  logic               clk,
  input  logic               rst,
  // configuration writes
  input  logic               write_enable,
  input  logic [1:0]         reg_index,
  input  logic [8:0]         write_data,
  // node transaction
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [15:0]        in_cost,
  input  logic signed [23:0] in_x,
  input  logic signed [23:0] in_y,
  input  logic [15:0]        in_heading,
  // successor transaction
  output logic               out_valid,
  input  logic               out_stall,
  output logic [15:0]        out_cost,
  output logic [16:0]        out_estimate,
  output logic signed [23:0] out_x,
  output logic signed [23:0] out_y,
  output logic [15:0]        out_heading,
  output logic               last_successor
);

  // number of steering angles, capped at the successor limit
  localparam int SPAN  = 2 * MAX_TURN_DEG;
  localparam int N_RAW = (SPAN + TURN_STEP_DEG - 1) / TURN_STEP_DEG + 1;
  localparam int N_OUT = (N_RAW > kse_pkg::MAX_OUT) ? kse_pkg::MAX_OUT : N_RAW;
  localparam logic [kse_pkg::KW-1:0] LAST_K = kse_pkg::KW'(N_OUT - 1);

  // per-angle heading increments, built at elaboration
  localparam logic [kse_pkg::MAX_OUT*16-1:0] INC_TAB =
    kse_pkg::build_tab(MAX_TURN_DEG, TURN_STEP_DEG, STEP_Q14, WHEELBASE_Q14);

  localparam logic signed [16:0] STEP_S = 17'(STEP_Q14);
  localparam logic signed [48:0] RND30  = 49'sd536870912;

  // configuration registers
  logic [8:0] goal_x;
  logic [8:0] goal_y;
  logic [2:0] hmode;

  always_ff @(posedge clk) begin
    if (rst) begin
      goal_x <= '0;
      goal_y <= '0;
      hmode  <= '0;
    end else if (write_enable) begin
      unique case (reg_index)
        kse_pkg::REG_GOAL_X: goal_x <= write_data;
        kse_pkg::REG_GOAL_Y: goal_y <= write_data;
        kse_pkg::REG_HMODE:  hmode  <= write_data[2:0];
        default: ;
      endcase
    end
  end

  // whole pipeline moves together; it holds while the expander still has successors
  logic                    busy;
  logic [kse_pkg::KW-1:0]  k;
  logic                    done;
  logic                    adv;

  assign done     = busy && !out_stall && (k == LAST_K);
  assign adv      = !busy || done;
  assign in_stall = !adv;

  // fold heading into a quarter turn either side of zero, flip marks the back half
  logic signed [16:0] fz;
  logic               fflip;
  kse_pkg::kse_node_t f_node;

  always_comb begin
    fflip = 1'b0;
    if (in_heading >= 16'd49152) begin
      fz = {1'b1, in_heading};
    end else if (in_heading > 16'd16384) begin
      fz    = {1'b0, in_heading} - 17'd32768;
      fflip = 1'b1;
    end else begin
      fz = {1'b0, in_heading};
    end
    f_node.cost = (in_cost == 16'hFFFF) ? in_cost : in_cost + 16'd1;
    f_node.x    = in_x;
    f_node.y    = in_y;
    f_node.head = in_heading;
  end

  // sine and cosine of the old heading
  logic               c_valid;
  logic signed [31:0] c_x, c_y;
  logic               c_flip;
  kse_pkg::kse_node_t c_node;

  kse_cordic u_cordic (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .in_valid  (in_valid),
    .in_z      (fz),
    .in_flip   (fflip),
    .in_node   (f_node),
    .out_valid (c_valid),
    .out_x     (c_x),
    .out_y     (c_y),
    .out_flip  (c_flip),
    .out_node  (c_node)
  );

  // step length times direction
  logic               m_valid;
  logic signed [48:0] m_px, m_py;
  kse_pkg::kse_node_t m_node;
  logic signed [31:0] cos_v, sin_v;

  assign cos_v = c_flip ? -c_x : c_x;
  assign sin_v = c_flip ? -c_y : c_y;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_valid <= 1'b0;
    end else if (adv) begin
      m_valid <= c_valid;
    end
    if (adv) begin
      m_px   <= STEP_S * cos_v;
      m_py   <= STEP_S * sin_v;
      m_node <= c_node;
    end
  end

  // round to q14, move and clamp
  logic signed [48:0] rpx, rpy;
  logic signed [25:0] sx, sy;
  logic               p_valid;
  kse_pkg::kse_node_t p_node;

  always_comb begin
    rpx = m_px + RND30;
    rpy = m_py + RND30;
    sx  = {{2{m_node.x[23]}}, m_node.x} + {{7{rpx[48]}}, rpx[48:30]};
    sy  = {{2{m_node.y[23]}}, m_node.y} + {{7{rpy[48]}}, rpy[48:30]};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid <= 1'b0;
    end else if (adv) begin
      p_valid <= m_valid;
    end
    if (adv) begin
      p_node.cost <= m_node.cost;
      p_node.x    <= kse_pkg::sat24(sx);
      p_node.y    <= kse_pkg::sat24(sy);
      p_node.head <= m_node.head;
    end
  end

  // heuristic and estimate
  logic               h_valid;
  kse_pkg::kse_node_t h_node;
  logic [16:0]        h_est;

  kse_heur u_heur (
    .clk          (clk),
    .rst          (rst),
    .adv          (adv),
    .goal_x       (goal_x),
    .goal_y       (goal_y),
    .hmode        (hmode),
    .in_valid     (p_valid),
    .in_node      (p_node),
    .out_valid    (h_valid),
    .out_node     (h_node),
    .out_estimate (h_est)
  );

  // expander: holds one node and walks the steering angles, one successor per transaction
  kse_pkg::kse_node_t e_node;
  logic [16:0]        e_est;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      k    <= '0;
    end else if (adv) begin
      busy <= h_valid;
      k    <= '0;
    end else if (busy && !out_stall) begin
      k <= k + 1'b1;
    end
    if (adv) begin
      e_node <= h_node;
      e_est  <= h_est;
    end
  end

  assign out_valid      = busy;
  assign out_cost       = e_node.cost;
  assign out_estimate   = e_est;
  assign out_x          = e_node.x;
  assign out_y          = e_node.y;
  assign out_heading    = e_node.head + INC_TAB[k*16 +: 16];
  assign last_successor = (k == LAST_K);

`ifndef SYNTHESIS
  // a node keeps its successors together until the last one
  a_node_held: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_stall && !last_successor) |=>
      (out_valid && out_cost == $past(out_cost) && out_x == $past(out_x)))
    else $error("successor run broke before the last one");

  // a held pipeline keeps its contents
  a_pipe_hold: assert property (@(posedge clk) disable iff (rst)
    (!adv && !rst) |=> (m_valid == $past(m_valid) && p_valid == $past(p_valid)))
    else $error("pipeline moved while held");

  // a stalled successor keeps its angle
  a_angle_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> $stable(k))
    else $error("steering index moved during stall");
`endif

endmodule

>>> tb/sv/testbench.sv
// self-checking testbench for kinematic_successor_expansion
// holds its own predictor of the successor set, drives nodes and checks every successor
// depends on kse_pkg and the rtl of kinematic_successor_expansion
`timescale 1ns / 1ps

module testbench;

  localparam int MAX_TURN  = 35;
  localparam int TURN_STEP = 5;
  localparam int STEP_LEN  = 23757;
  localparam int WHEELBASE = 8192;
  localparam int N_SUCC    = 15;
  localparam int SETTLE    = 70;   // longer than the pipeline from node to first successor
  localparam int STALL_LIM = 3000;
  localparam int LONG_HOLD = 400;

  typedef struct {
    logic [15:0]        cost;
    logic [16:0]        est;
    logic signed [23:0] x;
    logic signed [23:0] y;
    logic [15:0]        head;
    logic               last;
  } successor_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic write_enable = 1'b0;
  logic [1:0] reg_index = kse_pkg::REG_GOAL_X;
  logic [8:0] write_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [15:0] in_cost = '0;
  logic signed [23:0] in_x = '0;
  logic signed [23:0] in_y = '0;
  logic [15:0] in_heading = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [15:0] out_cost;
  logic [16:0] out_estimate;
  logic signed [23:0] out_x;
  logic signed [23:0] out_y;
  logic [15:0] out_heading;
  logic last_successor;

  kinematic_successor_expansion dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predictor copy of the configuration registers
  logic [8:0] goal_cx = '0;
  logic [8:0] goal_cy = '0;
  logic [2:0] hmode = kse_pkg::H_MANHATTAN;

  longint atan_tab [15] = '{8192, 4836, 2555, 1297, 651, 326, 163, 81, 41, 20, 10, 5, 3, 1, 1};
  logic [15:0] turn_inc [N_SUCC];

  kse_pkg::kse_node_t node_q [$];
  successor_t successor_q [$];
  int errors = 0;
  int idle_cycles = 0;
  bit src_idle = 1'b0;   // sender gaps on/off per phase
  bit snk_idle = 1'b0;   // receiver stalls on/off per phase
  bit long_req = 1'b0;

  // sine and cosine (q30) of a 16-bit turn angle, rotation cordic
  function automatic void sincos(input logic [15:0] ang, output longint c, output longint s);
    longint z;
    longint x;
    longint y;
    longint nx;
    bit flip;
    flip = 1'b0;
    if (ang >= 16'd49152) z = longint'(ang) - 65536;
    else if (ang > 16'd16384) begin
      z = longint'(ang) - 32768;
      flip = 1'b1;
    end else z = longint'(ang);
    x = 652032874;
    y = 0;
    for (int i = 0; i < 15; i++) begin
      if (z >= 0) begin
        nx = x - (y >>> i);
        y  = y + (x >>> i);
        z  = z - atan_tab[i];
      end else begin
        nx = x + (y >>> i);
        y  = y - (x >>> i);
        z  = z + atan_tab[i];
      end
      x = nx;
    end
    c = flip ? -x : x;
    s = flip ? -y : y;
  endfunction

  // heading change for one steering angle in degrees
  function automatic logic [15:0] heading_delta(int deg);
    longint unsigned mag;
    longint unsigned m;
    longint c;
    longint s;
    longint unsigned t;
    longint unsigned w;
    longint unsigned p;
    longint unsigned inc;
    mag = (deg < 0) ? -deg : deg;
    m = (mag * 65536 + 180) / 360;
    sincos(m[15:0], c, s);
    if (s < 0) s = 0;
    if (c <= 0) c = 1;
    t = ($unsigned(s) << 20) / $unsigned(c);
    w = (64'(STEP_LEN) * t) / 64'(WHEELBASE);
    p = w * 64'd174992710548 + (64'd1 << 43);
    inc = (p >> 44) & 64'hFFFF;
    if (deg < 0) inc = (64'd65536 - inc) & 64'hFFFF;
    return inc[15:0];
  endfunction

  function automatic longint unsigned floor_sqrt(longint unsigned v);
    longint unsigned r;
    longint unsigned b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else r = r >> 1;
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic longint clamp24(longint v);
    if (v > 8388607) return 8388607;
    if (v < -8388608) return -8388608;
    return v;
  endfunction

  // floored distance to the goal in cells for the current mode
  function automatic longint unsigned goal_distance(longint px, longint py);
    longint ex;
    longint ey;
    longint unsigned dx;
    longint unsigned dy;
    longint unsigned lo;
    longint unsigned hi;
    longint unsigned oct;
    ex = px - (longint'(goal_cx) << 14);
    ey = py - (longint'(goal_cy) << 14);
    dx = (ex < 0) ? -ex : ex;
    dy = (ey < 0) ? -ey : ey;
    lo = (dx < dy) ? dx : dy;
    hi = (dx < dy) ? dy : dx;
    oct = 2 * (dx + dy) + lo;
    unique case (hmode)
      kse_pkg::H_MANHATTAN:  return (dx + dy) >> 14;
      kse_pkg::H_CHEBYSHEV:  return hi >> 14;
      kse_pkg::H_OCTILE:     return oct >> 14;
      kse_pkg::H_EUCLID:     return floor_sqrt(dx * dx + dy * dy) >> 14;
      kse_pkg::H_OCTILE_TIE: return (oct * 11) / (10 * 16384);
      default:               return 0;  // unused modes give no heuristic
    endcase
  endfunction

  // all successors of one accepted node go onto successor_q
  task automatic expand_node(kse_pkg::kse_node_t n);
    longint c;
    longint s;
    longint nx;
    longint ny;
    longint unsigned cst;
    longint unsigned est;
    successor_t e;
    sincos(n.head, c, s);
    nx = clamp24(longint'(n.x) + ((64'(STEP_LEN) * c + (64'sd1 <<< 29)) >>> 30));
    ny = clamp24(longint'(n.y) + ((64'(STEP_LEN) * s + (64'sd1 <<< 29)) >>> 30));
    cst = (n.cost < 16'hFFFF) ? n.cost + 1 : 16'hFFFF;
    est = cst + goal_distance(nx, ny);
    if (est > 131071) est = 131071;
    for (int k = 0; k < N_SUCC; k++) begin
      e.cost = cst[15:0];
      e.est  = est[16:0];
      e.x    = nx[23:0];
      e.y    = ny[23:0];
      e.head = n.head + turn_inc[k];
      e.last = (k == N_SUCC - 1);
      successor_q.push_back(e);
    end
  endtask

  task automatic report(string what, longint got, longint want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    errors++;
  endtask

  // driver: presents queued nodes, random gap before each
  int gap = 0;
  kse_pkg::kse_node_t cur;
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && !in_stall) begin
        expand_node(cur);
        gap = src_idle ? $urandom_range(0, 14) : 0;
      end
      if (!in_valid || !in_stall) begin
        if (gap > 0) begin
          gap--;
          in_valid <= 1'b0;
        end else if (node_q.size() > 0) begin
          cur = node_q.pop_front();
          in_cost <= cur.cost;
          in_x <= cur.x;
          in_y <= cur.y;
          in_heading <= cur.head;
          in_valid <= 1'b1;
        end else in_valid <= 1'b0;
      end
    end
  end

  // monitor: checks each successor transaction, random stalls, one long hold-off
  int hold = 0;
  bit long_done = 1'b0;
  successor_t w;
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && !out_stall) begin
        if (successor_q.size() == 0) begin
          $display("unexpected successor at %0t", $realtime);
          errors++;
        end else begin
          w = successor_q.pop_front();
          if (out_cost !== w.cost) report("cost", out_cost, w.cost);
          if (out_estimate !== w.est) report("estimate", out_estimate, w.est);
          if (out_x !== w.x) report("x", out_x, w.x);
          if (out_y !== w.y) report("y", out_y, w.y);
          if (out_heading !== w.head) report("heading", out_heading, w.head);
          if (last_successor !== w.last) report("last", last_successor, w.last);
        end
        hold = snk_idle ? $urandom_range(0, 14) : 0;
      end
      if (long_req && !long_done) begin
        hold = LONG_HOLD;
        long_done = 1'b1;
      end
      if (hold > 0) begin
        hold--;
        out_stall <= 1'b1;
      end else out_stall <= 1'b0;
    end
  end

  // watchdog on cycles without any transaction
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIM) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  task automatic write_reg(logic [1:0] idx, logic [8:0] val);
    @(posedge clk);
    write_enable <= 1'b1;
    reg_index <= idx;
    write_data <= val;
    @(posedge clk);
    write_enable <= 1'b0;
    unique case (idx)
      kse_pkg::REG_GOAL_X: goal_cx = val;
      kse_pkg::REG_GOAL_Y: goal_cy = val;
      default:             hmode = val[2:0];
    endcase
  endtask

  task automatic push_node(logic [15:0] c, logic [23:0] x, logic [23:0] y, logic [15:0] h);
    kse_pkg::kse_node_t n;
    n.cost = c;
    n.x = x;
    n.y = y;
    n.head = h;
    node_q.push_back(n);
  endtask

  // let everything drain, then wait out the pipeline
  task automatic drain();
    while (node_q.size() > 0 || in_valid || successor_q.size() > 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // random node, mostly near the goal so the heuristic stays small
  task automatic random_node();
    logic [23:0] x;
    logic [23:0] y;
    if ($urandom_range(0, 3) == 0) begin
      x = 24'($urandom);
      y = 24'($urandom);
    end else begin
      x = 24'((longint'(goal_cx) << 14) + longint'($urandom_range(0, 262143)) - 131072);
      y = 24'((longint'(goal_cy) << 14) + longint'($urandom_range(0, 262143)) - 131072);
    end
    push_node(16'($urandom), x, y, 16'($urandom));
  endtask

  initial begin
    logic [2:0] m;
    for (int k = 0; k < N_SUCC; k++) turn_inc[k] = heading_delta(-MAX_TURN + k * TURN_STEP);
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // directed: field extremes, cardinal headings, saturation of cost and position
    write_reg(kse_pkg::REG_GOAL_X, 9'd0);
    write_reg(kse_pkg::REG_GOAL_Y, 9'd0);
    write_reg(kse_pkg::REG_HMODE, {6'd0, kse_pkg::H_MANHATTAN});
    push_node(16'd0, 24'd0, 24'd0, 16'd0);
    push_node(16'hFFFF, 24'h7FFFFF, 24'h7FFFFF, 16'd0);
    push_node(16'hFFFE, 24'h800000, 24'h800000, 16'd32768);
    push_node(16'd1, 24'h7FFFFF, 24'h000000, 16'd16384);
    push_node(16'd2, 24'h800000, 24'h7FFFFF, 16'd49152);
    push_node(16'd3, 24'h000100, 24'hFFFF00, 16'hFFFF);
    push_node(16'd4, 24'h123456, 24'hEDCBA9, 16'd16385);
    push_node(16'd5, 24'hFFFFFF, 24'h000001, 16'd49151);
    push_node(16'hAAAA, 24'h555555, 24'hAAAAAA, 16'h5555);
    drain();

    // goals at both ends, every heuristic mode including the unused ones
    for (int ph = 0; ph < 12; ph++) begin
      m = (ph < 8) ? ph[2:0] : 3'($urandom_range(0, 4));
      write_reg(kse_pkg::REG_GOAL_X,
                (ph % 3 == 0) ? 9'd511 : (ph % 3 == 1) ? 9'd0 : 9'($urandom));
      write_reg(kse_pkg::REG_GOAL_Y,
                (ph % 4 == 0) ? 9'd0 : (ph % 4 == 1) ? 9'd511 : 9'($urandom));
      write_reg(kse_pkg::REG_HMODE, {6'd0, m});
      src_idle = ph[0];
      snk_idle = ph[1] | ph[2];
      if (ph == 4) long_req = 1'b1;  // receiver holds off while nodes keep coming
      for (int i = 0; i < 26; i++) random_node();
      drain();
    end

    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
